### hdl/ofpre_pkg.sv
// Package for the OOK frame pulse run encoder.
// Holds the frame constants, field widths and register indexes.
// Used by the top level and by its checker.
package ofpre_pkg;

  localparam int FRAME_BITS = 96;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS);
  localparam int DUR_W      = 17;
  localparam int TIME_W     = 10;
  localparam int ADDR_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_HI_BYTE  = 8'h2D;
  localparam logic [BYTE_W-1:0] SYNC_LO_BYTE  = 8'hD4;
  localparam logic [BYTE_W-1:0] RSVD_BYTE     = 8'h00;

  localparam logic [ADDR_W-1:0] ADDR_RESET  = 16'd0;
  localparam logic [TIME_W-1:0] MARK_RESET  = 10'd105;
  localparam logic [TIME_W-1:0] SPACE_RESET = 10'd104;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_TIME      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_TIME     = 2'd2;

  typedef logic [DUR_W-1:0] dur_t;

endpackage

### hdl/ook_frame_pulse_run_encoder.sv
// OOK frame pulse run encoder, top level.
// Builds a 12-byte frame per word and emits its bit runs as duration pairs.
// Depends on ofpre_pkg.

// Each input word (command and mode byte) produces one 96-bit frame: four 0xAA
// preamble bytes, sync 0x2D 0xD4, the device address high byte first, a zero
// byte, command, mode and a checksum that makes bytes 4 to 10 plus itself sum
// to zero. The frame is scanned MSB first, one bit per cycle unless a pair waits
// on a stalled output, with a single shared adder that adds mark_time or
// space_time into the current high or low run total. Each output word is a
// (high, low) run pair; the last one has last_pair set and a low duration of
// zero when the frame ends on a one bit. in_ready is low while a frame is in work.
// The cfg port is always ready, but registers should be written only between
// frames, since mark_time and space_time are read throughout the scan.
module ook_frame_pulse_run_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ofpre_pkg::BYTE_W-1:0]   in_command_code,
  input  logic [ofpre_pkg::BYTE_W-1:0]   in_mode_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ofpre_pkg::DUR_W-1:0]    out_high_duration,
  output logic [ofpre_pkg::DUR_W-1:0]    out_low_duration,
  output logic                           out_last_pair,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ofpre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ofpre_pkg::ADDR_W-1:0]   cfg_data
);
  import ofpre_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

  logic [1:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     addr_r;
  logic [TIME_W-1:0]     mark_r;
  logic [TIME_W-1:0]     space_r;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  dur_t                  hi_acc_r, hi_acc_nxt;
  dur_t                  lo_acc_r, lo_acc_nxt;
  logic                  zrun_r, zrun_nxt;

  logic                  out_valid_r, out_valid_nxt;
  dur_t                  out_hi_r, out_hi_nxt;
  dur_t                  out_lo_r, out_lo_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_accept;
  logic [BYTE_W-1:0]     sum8;
  logic [BYTE_W-1:0]     csum;
  logic                  cur_bit;
  logic                  need_emit;
  logic                  out_free;
  dur_t                  add_a;
  logic [TIME_W-1:0]     add_b;
  dur_t                  add_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_high_duration = out_hi_r;
  assign out_low_duration  = out_lo_r;
  assign out_last_pair     = out_last_r;

  // Checksum: two's-complement negation of the byte sum of sync to mode.
  assign sum8 = BYTE_W'(SYNC_HI_BYTE + SYNC_LO_BYTE + addr_r[ADDR_W-1:BYTE_W]
                        + addr_r[BYTE_W-1:0] + RSVD_BYTE + in_command_code
                        + in_mode_code);
  assign csum = BYTE_W'(8'd0 - sum8);

  assign cur_bit   = frame_r[FRAME_BITS-1];
  assign need_emit = cur_bit && zrun_r;
  assign out_free  = !out_valid_r || out_ready;

  // The one shared adder. A one bit after a zero run restarts the high total.
  always_comb begin
    add_a   = need_emit ? '0 : (cur_bit ? hi_acc_r : lo_acc_r);
    add_b   = cur_bit ? mark_r : space_r;
    add_sum = add_a + DUR_W'(add_b);
  end

  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    bit_cnt_nxt   = bit_cnt_r;
    hi_acc_nxt    = hi_acc_r;
    lo_acc_nxt    = lo_acc_r;
    zrun_nxt      = zrun_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hi_nxt    = out_hi_r;
    out_lo_nxt    = out_lo_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          frame_nxt   = {PREAMBLE_BYTE, PREAMBLE_BYTE, PREAMBLE_BYTE, PREAMBLE_BYTE,
                         SYNC_HI_BYTE, SYNC_LO_BYTE, addr_r, RSVD_BYTE,
                         in_command_code, in_mode_code, csum};
          bit_cnt_nxt = '0;
          hi_acc_nxt  = '0;
          lo_acc_nxt  = '0;
          zrun_nxt    = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!need_emit || out_free) begin
          if (need_emit) begin
            out_valid_nxt = 1'b1;
            out_hi_nxt    = hi_acc_r;
            out_lo_nxt    = lo_acc_r;
            out_last_nxt  = 1'b0;
            lo_acc_nxt    = '0;
            zrun_nxt      = 1'b0;
          end
          if (cur_bit) begin
            hi_acc_nxt = add_sum;
          end else begin
            lo_acc_nxt = add_sum;
            zrun_nxt   = 1'b1;
          end
          frame_nxt   = {frame_r[FRAME_BITS-2:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          if (bit_cnt_r == LAST_BIT) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hi_nxt    = hi_acc_r;
          out_lo_nxt    = lo_acc_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      addr_r      <= ADDR_RESET;
      mark_r      <= MARK_RESET;
      space_r     <= SPACE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEVICE_ADDRESS: addr_r  <= cfg_data;
          REG_MARK_TIME:      mark_r  <= cfg_data[TIME_W-1:0];
          REG_SPACE_TIME:     space_r <= cfg_data[TIME_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_r    <= frame_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    hi_acc_r   <= hi_acc_nxt;
    lo_acc_r   <= lo_acc_nxt;
    zrun_r     <= zrun_nxt;
    out_hi_r   <= out_hi_nxt;
    out_lo_r   <= out_lo_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### hdl/ofpre_checker.sv
// Port-level checker for the OOK frame pulse run encoder.
// Bound to ook_frame_pulse_run_encoder; depends on ofpre_pkg.
module ofpre_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ofpre_pkg::DUR_W-1:0]   out_high_duration,
  input logic [ofpre_pkg::DUR_W-1:0]   out_low_duration,
  input logic                          out_last_pair
);
  import ofpre_pkg::*;

  // No result word is presented right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_high_duration)
      && $stable(out_low_duration) && $stable(out_last_pair))
    else $error("stalled output word changed");

  // A frame stays in work after acceptance; no second word is taken right away.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input ready too soon after a word");

  // While pairs short of the last one leave, the frame is still in work.
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pair |-> !in_ready)
    else $error("input ready before the final pair");

endmodule

bind ook_frame_pulse_run_encoder ofpre_checker u_ofpre_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_high_duration (out_high_duration),
  .out_low_duration  (out_low_duration),
  .out_last_pair     (out_last_pair)
);

### test/ook_frame_pulse_run_encoder_test.sv
`timescale 1ns / 100ps
// Testbench for ook_frame_pulse_run_encoder: feeds command/mode words, predicts the
// run pairs of each frame and checks them in order under several idling patterns.
// Depends on ofpre_pkg and the encoder top level.
module ook_frame_pulse_run_encoder_test;
  import ofpre_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 110;
  localparam int RANDOM_WORDS  = 45;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] mode;
  } request_t;

  typedef struct packed {
    dur_t high_dur;
    dur_t low_dur;
    logic last;
  } run_pair_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_command_code = '0;
  logic [BYTE_W-1:0]    in_mode_code = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dur_t                 out_high_duration;
  dur_t                 out_low_duration;
  logic                 out_last_pair;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  request_t  pending_requests[$];
  run_pair_t expected_pairs[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  int        cycle_count = 0;

  // Register copies used by the frame predictor.
  logic [ADDR_W-1:0] device_addr_q = ADDR_RESET;
  logic [TIME_W-1:0] mark_units = MARK_RESET;
  logic [TIME_W-1:0] space_units = SPACE_RESET;

  ook_frame_pulse_run_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command_code   (in_command_code),
    .in_mode_code      (in_mode_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_high_duration (out_high_duration),
    .out_low_duration  (out_low_duration),
    .out_last_pair     (out_last_pair),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic run_pair_t make_pair(input int ones_run, input int zeros_run,
                                          input logic last);
    run_pair_t pair;
    pair.high_dur = dur_t'(ones_run * int'(mark_units));
    pair.low_dur  = dur_t'(zeros_run * int'(space_units));
    pair.last     = last;
    return pair;
  endfunction

  // Builds the 96-bit frame for one word and queues its (high, low) run pairs.
  function automatic void encode_frame_runs(input request_t req);
    logic [FRAME_BITS-1:0] frame_bits;
    logic [BYTE_W-1:0]     byte_sum;
    logic [BYTE_W-1:0]     checksum;
    int                    ones_run;
    int                    zeros_run;
    byte_sum = SYNC_HI_BYTE + SYNC_LO_BYTE + device_addr_q[15:8] + device_addr_q[7:0]
               + RSVD_BYTE + req.command + req.mode;
    checksum = 8'd0 - byte_sum;
    frame_bits = {{4{PREAMBLE_BYTE}}, SYNC_HI_BYTE, SYNC_LO_BYTE, device_addr_q,
                  RSVD_BYTE, req.command, req.mode, checksum};
    ones_run = 0;
    zeros_run = 0;
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      if (frame_bits[i]) begin
        // A one after a zero run closes the current pair.
        if (zeros_run != 0) begin
          expected_pairs = {expected_pairs, make_pair(ones_run, zeros_run, 1'b0)};
          ones_run = 0;
          zeros_run = 0;
        end
        ones_run++;
      end else begin
        zeros_run++;
      end
    end
    expected_pairs = {expected_pairs, make_pair(ones_run, zeros_run, 1'b1)};
  endfunction

  // Input driver.
  always @(posedge clk) begin : driver
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req.command = in_command_code;
        req.mode = in_mode_code;
        encode_frame_runs(req);
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_command_code <= req.command;
          in_mode_code <= req.mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin : monitor
    run_pair_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          errors++;
          $error("run pair with no word pending: high %0d low %0d last %0b",
                 out_high_duration, out_low_duration, out_last_pair);
        end else begin
          want = expected_pairs.pop_front();
          if (out_high_duration !== want.high_dur) begin
            errors++;
            $error("high_duration: expected %0d, got %0d", want.high_dur, out_high_duration);
          end
          if (out_low_duration !== want.low_dur) begin
            errors++;
            $error("low_duration: expected %0d, got %0d", want.low_dur, out_low_duration);
          end
          if (out_last_pair !== want.last) begin
            errors++;
            $error("last_pair: expected %0b, got %0b", want.last, out_last_pair);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Register copies follow every accepted write; unknown indexes are dropped.
  always @(posedge clk) begin
    if (!rst_n) begin
      device_addr_q <= ADDR_RESET;
      mark_units <= MARK_RESET;
      space_units <= SPACE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: device_addr_q <= cfg_data;
        REG_MARK_TIME:      mark_units <= cfg_data[TIME_W-1:0];
        REG_SPACE_TIME:     space_units <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ook_frame_pulse_run_encoder_test: FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic [BYTE_W-1:0] command, input logic [BYTE_W-1:0] mode);
    request_t req;
    req.command = command;
    req.mode = mode;
    pending_requests = {pending_requests, req};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every word is taken and every pair has come back, then lets the
  // encoder settle before any register write.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_pairs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct,
                              input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] mark,
                              input logic [ADDR_W-1:0] space);
    wait_drained();
    write_reg(REG_DEVICE_ADDRESS, addr);
    write_reg(REG_MARK_TIME, mark);
    write_reg(REG_SPACE_TIME, space);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (RANDOM_WORDS)
      queue_request(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings. An all-zero word makes the checksum 0xFF, so the frame
    // ends on a one bit.
    queue_request(8'h00, 8'h00);
    queue_request(8'hFF, 8'hFF);
    queue_request(8'h00, 8'hFF);
    queue_request(8'hFF, 8'h00);
    queue_request(8'hAA, 8'h55);
    queue_request(8'h55, 8'hAA);
    queue_request(8'h80, 8'h01);
    queue_request(8'h01, 8'h80);
    queue_request(8'h2D, 8'hD4);

    // Largest durations; upper data bits must be dropped, and a write to an
    // unused index must change nothing.
    wait_drained();
    write_reg(REG_DEVICE_ADDRESS, 16'hFFFF);
    write_reg(REG_MARK_TIME, 16'hFFFF);
    write_reg(REG_SPACE_TIME, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0042);
    queue_request(8'hFF, 8'hFF);
    queue_request(8'h00, 8'h00);
    queue_request(8'h7F, 8'hFE);
    queue_request(8'hFE, 8'h7F);

    // Zero durations still yield one pair per run.
    wait_drained();
    write_reg(REG_DEVICE_ADDRESS, 16'h2DD4);
    write_reg(REG_MARK_TIME, 16'h0000);
    write_reg(REG_SPACE_TIME, 16'h0000);
    queue_request(8'h00, 8'h00);
    queue_request(8'hFF, 8'hFF);
    queue_request(8'h5A, 8'hA5);

    random_phase(0, 0, ADDR_W'($urandom_range(65535)), 16'hFC01, 16'h0401);
    random_phase(55, 0, ADDR_W'($urandom_range(65535)), ADDR_W'($urandom_range(65535)),
                 ADDR_W'($urandom_range(65535)));
    random_phase(0, 55, ADDR_W'($urandom_range(65535)), ADDR_W'($urandom_range(65535)),
                 ADDR_W'($urandom_range(65535)));
    random_phase(33, 33, ADDR_W'($urandom_range(65535)), 16'h03FF,
                 ADDR_W'($urandom_range(65535)));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ook_frame_pulse_run_encoder_test: PASS");
    end else begin
      $display("ook_frame_pulse_run_encoder_test: FAIL");
    end
    $finish;
  end

endmodule

### ook_frame_pulse_run_encoder.f
hdl/ofpre_pkg.sv
hdl/ook_frame_pulse_run_encoder.sv
hdl/ofpre_checker.sv
test/ook_frame_pulse_run_encoder_test.sv
